// ===== design/tri_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangulation angle package
// Shared payload types, widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tri_pkg;

	localparam int CoordW  = 32;
	localparam int RayW    = 33;
	localparam int RedW    = 22;   // reduced ray component, |r| < 2^21
	localparam int ProdW   = 46;   // one product of reduced components
	localparam int DotW    = 47;   // sum or difference of products
	localparam int NormW   = 30;   // normalized magnitude, < 2^30
	localparam int SqW     = 62;   // sum of three squares, < 3 * 2^60
	localparam int RootW   = 31;   // floor square root
	localparam int CordW   = 34;   // CORDIC x and y
	localparam int ZW      = 34;   // CORDIC angle accumulator, Q.30
	localparam int AngW    = 17;
	localparam int CordN   = 30;
	localparam int SqrtN   = 31;   // result bits of the square root
	localparam int AngMax  = 102944;
	localparam int RayLimB = 21;

	typedef struct packed {
		logic signed [CoordW-1:0] center1_x;
		logic signed [CoordW-1:0] center1_y;
		logic signed [CoordW-1:0] center1_z;
		logic signed [CoordW-1:0] center2_x;
		logic signed [CoordW-1:0] center2_y;
		logic signed [CoordW-1:0] center2_z;
		logic signed [CoordW-1:0] point_x;
		logic signed [CoordW-1:0] point_y;
		logic signed [CoordW-1:0] point_z;
	} tri_in_t;

	typedef struct packed {
		logic [AngW-1:0] angle;
		logic            degenerate;
	} tri_out_t;

	// Control that travels with each item along the pipeline
	typedef struct packed {
		logic vld;
		logic degen;
		logic zero_mag;
	} tri_ctl_t;

	function automatic logic [ZW-1:0] atan_q30(input logic [4:0] i);
		logic [ZW-1:0] r;
		unique case (i)
			5'd0: r = 34'd843314856;
			5'd1: r = 34'd497837829;
			5'd2: r = 34'd263043836;
			5'd3: r = 34'd133525158;
			5'd4: r = 34'd67021686;
			5'd5: r = 34'd33543515;
			5'd6: r = 34'd16775850;
			5'd7: r = 34'd8388437;
			5'd8: r = 34'd4194282;
			5'd9: r = 34'd2097149;
			5'd10: r = 34'd1048575;
			5'd11: r = 34'd524287;
			5'd12: r = 34'd262143;
			5'd13: r = 34'd131071;
			5'd14: r = 34'd65535;
			5'd15: r = 34'd32767;
			5'd16: r = 34'd16383;
			5'd17: r = 34'd8191;
			5'd18: r = 34'd4095;
			5'd19: r = 34'd2047;
			5'd20: r = 34'd1023;
			5'd21: r = 34'd511;
			5'd22: r = 34'd255;
			5'd23: r = 34'd127;
			5'd24: r = 34'd63;
			5'd25: r = 34'd31;
			5'd26: r = 34'd15;
			5'd27: r = 34'd7;
			5'd28: r = 34'd3;
			5'd29: r = 34'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/triangulation_angle.sv =====
// ----------------------------------------------------------------------------
// Triangulation angle
// Minimum ray intersection angle of one point seen from two centres.
// ----------------------------------------------------------------------------
//  channel | handshake     | payload
//  in      | valid, stall  | in  (tri_in_t, nine Q16.16 coordinates)
//  out     | valid, stall  | out (tri_out_t, angle Q1.16 and degenerate)
//
// One item per cycle while the output does not stall. A single enable advances
// the whole pipeline and an output skid register takes the last result, so a
// stall on a valid result halts all stages in the next cycle without loss.
// Reset clears only the control bits (valid, degenerate, zero magnitude) and
// the skid flag, not the data registers.
// ----------------------------------------------------------------------------
module triangulation_angle import tri_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  tri_in_t  in,
	output logic     out_valid,
	input  logic     out_stall,
	output tri_out_t out
);

	logic             en;
	tri_ctl_t         f_ctl, s_ctl;
	logic [NormW-1:0] nx, nc0, nc1, nc2, sx;
	logic [RootW-1:0] root;
	logic             p_vld;
	tri_out_t         p_out;
	logic             skid_q;
	tri_out_t         skid_data_q;

	// Advance when the skid register is empty
	assign en = !skid_q;
	assign in_stall = skid_q;

	tri_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(in_valid && !in_stall),
		.din(in), .ctl(f_ctl), .nx(nx), .nc0(nc0), .nc1(nc1), .nc2(nc2)
	);

	tri_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl_in(f_ctl), .nx(nx),
		.nc0(nc0), .nc1(nc1), .nc2(nc2), .ctl(s_ctl), .xo(sx), .root(root)
	);

	tri_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl_in(s_ctl), .xi(sx),
		.yi(root), .vld(p_vld), .dout(p_out)
	);

	// Hold a result in the skid register when the output stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (!skid_q) begin
			skid_q <= p_vld && out_stall;
		end else if (!out_stall) begin
			skid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_q) begin
			skid_data_q <= p_out;
		end
	end

	assign out_valid = skid_q || p_vld;
	assign out = skid_q ? skid_data_q : p_out;

`ifndef SYNTHESIS
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q && out_stall |=> skid_q && $stable(skid_data_q))
		else $error("skid register lost a stalled result");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q |=> $stable(p_out) && $stable(p_vld))
		else $error("pipeline advanced while skid full");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out.degenerate |-> out.angle == '0)
		else $error("degenerate result with nonzero angle");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out.angle <= AngW'(AngMax))
		else $error("angle out of range");
`endif

endmodule

// ===== design/tri_front.sv =====
// ----------------------------------------------------------------------------
// Triangulation angle front end
// Ray differences, per-ray reduction, exact dot and cross products,
// common normalization. Five register stages.
// ----------------------------------------------------------------------------
module tri_front import tri_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  tri_in_t              din,
	output tri_ctl_t             ctl,
	output logic [NormW-1:0]     nx,
	output logic [NormW-1:0]     nc0,
	output logic [NormW-1:0]     nc1,
	output logic [NormW-1:0]     nc2
);

	// ---------------- stage 1: differences
	logic signed [RayW-1:0] u_s1 [3];
	logic signed [RayW-1:0] v_s1 [3];
	tri_ctl_t ctl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.vld <= in_vld;
			ctl_s1.degen <= 1'b0;
			ctl_s1.zero_mag <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1[0] <= RayW'(din.point_x) - RayW'(din.center1_x);
			u_s1[1] <= RayW'(din.point_y) - RayW'(din.center1_y);
			u_s1[2] <= RayW'(din.point_z) - RayW'(din.center1_z);
			v_s1[0] <= RayW'(din.point_x) - RayW'(din.center2_x);
			v_s1[1] <= RayW'(din.point_y) - RayW'(din.center2_y);
			v_s1[2] <= RayW'(din.point_z) - RayW'(din.center2_z);
		end
	end

	// ---------------- stage 2: reduce each ray below 2^21
	function automatic logic [RayW-1:0] absv(input logic signed [RayW-1:0] a);
		return a[RayW-1] ? RayW'(-a) : a;
	endfunction

	function automatic logic [3:0] ray_shift(input logic [RayW-1:0] m);
		logic [3:0] s;
		s = '0;
		for (int k = RayW-1; k >= RayLimB; k--) begin
			if (m[k] && s == '0) s = 4'(k - RayLimB + 1);
		end
		return s;
	endfunction

	logic [RayW-1:0] ua [3];
	logic [RayW-1:0] va [3];
	logic [RayW-1:0] um, vm;
	logic [3:0]      us, vs;
	logic            uz, vz;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ua[i] = absv(u_s1[i]);
			va[i] = absv(v_s1[i]);
		end
		um = ua[0] | ua[1] | ua[2];
		vm = va[0] | va[1] | va[2];
		us = ray_shift(um);
		vs = ray_shift(vm);
		uz = (um == '0);
		vz = (vm == '0);
	end

	logic signed [RedW-1:0] u_s2 [3];
	logic signed [RedW-1:0] v_s2 [3];
	tri_ctl_t ctl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2.vld <= ctl_s1.vld;
			ctl_s2.degen <= uz | vz;
			ctl_s2.zero_mag <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				u_s2[i] <= u_s1[i][RayW-1] ? -RedW'(ua[i] >> us) : RedW'(ua[i] >> us);
				v_s2[i] <= v_s1[i][RayW-1] ? -RedW'(va[i] >> vs) : RedW'(va[i] >> vs);
			end
		end
	end

	// ---------------- stage 3: nine products
	logic signed [ProdW-1:0] p_s3 [9];
	tri_ctl_t ctl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3[0] <= ProdW'(u_s2[0]) * ProdW'(v_s2[0]);
			p_s3[1] <= ProdW'(u_s2[1]) * ProdW'(v_s2[1]);
			p_s3[2] <= ProdW'(u_s2[2]) * ProdW'(v_s2[2]);
			p_s3[3] <= ProdW'(u_s2[1]) * ProdW'(v_s2[2]);
			p_s3[4] <= ProdW'(u_s2[2]) * ProdW'(v_s2[1]);
			p_s3[5] <= ProdW'(u_s2[2]) * ProdW'(v_s2[0]);
			p_s3[6] <= ProdW'(u_s2[0]) * ProdW'(v_s2[2]);
			p_s3[7] <= ProdW'(u_s2[0]) * ProdW'(v_s2[1]);
			p_s3[8] <= ProdW'(u_s2[1]) * ProdW'(v_s2[0]);
		end
	end

	// ---------------- stage 4: sums and magnitudes
	logic signed [DotW-1:0] dsum, c0, c1, c2;
	logic [DotW-1:0] a_s4 [4];
	tri_ctl_t ctl_s4;

	always_comb begin
		dsum = DotW'(p_s3[0]) + DotW'(p_s3[1]) + DotW'(p_s3[2]);
		c0 = DotW'(p_s3[3]) - DotW'(p_s3[4]);
		c1 = DotW'(p_s3[5]) - DotW'(p_s3[6]);
		c2 = DotW'(p_s3[7]) - DotW'(p_s3[8]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4[0] <= dsum[DotW-1] ? DotW'(-dsum) : dsum;
			a_s4[1] <= c0[DotW-1] ? DotW'(-c0) : c0;
			a_s4[2] <= c1[DotW-1] ? DotW'(-c1) : c1;
			a_s4[3] <= c2[DotW-1] ? DotW'(-c2) : c2;
		end
	end

	// ---------------- stage 5: normalize so the largest lies in [2^29, 2^30)
	logic [DotW-1:0] am;
	logic [5:0]      lead;
	logic            found;

	always_comb begin
		am = a_s4[0] | a_s4[1] | a_s4[2] | a_s4[3];
		lead = '0;
		found = 1'b0;
		for (int k = DotW-1; k >= 0; k--) begin
			if (am[k] && !found) begin
				lead = 6'(k);
				found = 1'b1;
			end
		end
	end

	function automatic logic [NormW-1:0] norm(input logic [DotW-1:0] a,
			input logic [5:0] ld);
		logic [DotW+NormW-1:0] w;
		w = {a, {NormW{1'b0}}} >> (ld + 6'd1);
		return w[NormW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl <= '0;
		end else if (en) begin
			ctl.vld <= ctl_s4.vld;
			ctl.degen <= ctl_s4.degen;
			ctl.zero_mag <= !found;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx  <= norm(a_s4[0], lead);
			nc0 <= norm(a_s4[1], lead);
			nc1 <= norm(a_s4[2], lead);
			nc2 <= norm(a_s4[3], lead);
		end
	end

endmodule

// ===== design/tri_sqrt.sv =====
// ----------------------------------------------------------------------------
// Triangulation angle square root
// Sum of squares, then a restoring square root, one result bit per stage.
// The X operand and control ride alongside.
// ----------------------------------------------------------------------------
module tri_sqrt import tri_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  tri_ctl_t         ctl_in,
	input  logic [NormW-1:0] nx,
	input  logic [NormW-1:0] nc0,
	input  logic [NormW-1:0] nc1,
	input  logic [NormW-1:0] nc2,
	output tri_ctl_t         ctl,
	output logic [NormW-1:0] xo,
	output logic [RootW-1:0] root
);

	// ---------------- squares
	logic [2*NormW-1:0] q_s1 [3];
	logic [NormW-1:0]   x_s1;
	tri_ctl_t           c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s1 <= '0;
		end else if (en) begin
			c_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1[0] <= nc0 * nc0;
			q_s1[1] <= nc1 * nc1;
			q_s1[2] <= nc2 * nc2;
			x_s1 <= nx;
		end
	end

	// ---------------- sum
	logic [SqW-1:0]   n_s2;
	logic [NormW-1:0] x_s2;
	tri_ctl_t         c_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s2 <= '0;
		end else if (en) begin
			c_s2 <= c_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2 <= SqW'(q_s1[0]) + SqW'(q_s1[1]) + SqW'(q_s1[2]);
			x_s2 <= x_s1;
		end
	end

	// ---------------- restoring root, one bit per stage
	localparam int RemW = RootW + 2;

	logic [SqW-1:0]   rad_p  [SqrtN+1];
	logic [RemW-1:0]  rem_p  [SqrtN+1];
	logic [RootW-1:0] res_p  [SqrtN+1];
	logic [NormW-1:0] x_p    [SqrtN+1];
	tri_ctl_t         c_p    [SqrtN+1];

	assign rad_p[0] = n_s2;
	assign rem_p[0] = '0;
	assign res_p[0] = '0;
	assign x_p[0] = x_s2;
	assign c_p[0] = c_s2;

	for (genvar g = 0; g < SqrtN; g++) begin : g_root
		logic [RemW-1:0] tr;
		logic [RemW-1:0] tt;
		logic            ok;

		always_comb begin
			tr = {rem_p[g][RemW-3:0], rad_p[g][SqW-1:SqW-2]};
			tt = {res_p[g], 2'b01};
			ok = (tr >= tt);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_p[g+1] <= '0;
			end else if (en) begin
				c_p[g+1] <= c_p[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_p[g+1] <= {rad_p[g][SqW-3:0], 2'b00};
				rem_p[g+1] <= ok ? RemW'(tr - tt) : tr;
				res_p[g+1] <= {res_p[g][RootW-2:0], ok};
				x_p[g+1] <= x_p[g];
			end
		end
	end

	assign ctl = c_p[SqrtN];
	assign xo = x_p[SqrtN];
	assign root = res_p[SqrtN];

endmodule

// ===== design/tri_cordic.sv =====
// ----------------------------------------------------------------------------
// Triangulation angle CORDIC
// Thirty vectoring iterations, one per stage, then rounding and clamping.
// ----------------------------------------------------------------------------
module tri_cordic import tri_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  tri_ctl_t         ctl_in,
	input  logic [NormW-1:0] xi,
	input  logic [RootW-1:0] yi,
	output logic             vld,
	output tri_out_t         dout
);

	logic signed [CordW-1:0] x_p [CordN+1];
	logic signed [CordW-1:0] y_p [CordN+1];
	logic signed [ZW-1:0]    z_p [CordN+1];
	tri_ctl_t                c_p [CordN+1];

	assign x_p[0] = CordW'(xi);
	assign y_p[0] = CordW'(yi);
	assign z_p[0] = '0;
	assign c_p[0] = ctl_in;

	// ---------------- one rotation per stage
	for (genvar g = 0; g < CordN; g++) begin : g_rot
		logic signed [CordW-1:0] xs, ys;
		always_comb begin
			xs = x_p[g] >>> g;
			ys = y_p[g] >>> g;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_p[g+1] <= '0;
			end else if (en) begin
				c_p[g+1] <= c_p[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_p[g][CordW-1]) begin
					x_p[g+1] <= x_p[g] + ys;
					y_p[g+1] <= y_p[g] - xs;
					z_p[g+1] <= z_p[g] + atan_q30(5'(g));
				end else begin
					x_p[g+1] <= x_p[g] - ys;
					y_p[g+1] <= y_p[g] + xs;
					z_p[g+1] <= z_p[g] - atan_q30(5'(g));
				end
			end
		end
	end

	// ---------------- round to Q1.16 and clamp
	logic signed [ZW-1:0] zf, zr;
	logic [AngW-1:0]      ang;

	always_comb begin
		zf = z_p[CordN];
		zr = (zf + ZW'(1 << 13)) >>> 14;
		if (zf[ZW-1] || zf == '0 || c_p[CordN].degen || c_p[CordN].zero_mag) begin
			ang = '0;
		end else if (zr > ZW'(AngMax)) begin
			ang = AngW'(AngMax);
		end else begin
			ang = zr[AngW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= 1'b0;
		end else if (en) begin
			vld <= c_p[CordN].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout.angle <= ang;
			dout.degenerate <= c_p[CordN].degen;
		end
	end

endmodule

// ===== test/tb_triangulation_angle.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangulation angle testbench
// Streams camera-pair observations through the block with random idle bursts
// on both sides and checks every angle and degenerate flag against an
// integer predictor of the ray reduction, scaling, square root and CORDIC.
// ----------------------------------------------------------------------------
module tb_triangulation_angle;
	import tri_pkg::*;

	localparam int NumRandom = 1900;
	localparam int Latency   = 69;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	tri_in_t  in;
	logic     out_valid;
	logic     out_stall;
	tri_out_t out;

	tri_in_t  pending_obs[$];
	tri_out_t expected_angles[$];
	int       n_mismatch;
	int       n_checked;
	int       n_degenerate;
	bit       stim_done;
	bit       quiet;
	int       in_gap;
	int       out_gap;

	triangulation_angle dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in       (in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out      (out)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint floor_shift(longint v, int k);
		return v >>> k;
	endfunction

	// shrink one ray so its largest component is below 2^21
	function automatic void shrink_ray(ref longint r[3]);
		longint unsigned m;
		int s;
		longint q;
		m = 0;
		s = 0;
		for (int i = 0; i < 3; i++)
			if (magnitude(r[i]) > m)
				m = magnitude(r[i]);
		while ((m >> s) >= (64'd1 << RayLimB))
			s++;
		for (int i = 0; i < 3; i++) begin
			q = longint'(magnitude(r[i]) >> s);
			r[i] = r[i] < 0 ? -q : q;
		end
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic tri_out_t predict_angle(tri_in_t o);
		tri_out_t r;
		longint u[3];
		longint v[3];
		longint c[3];
		longint p[3];
		longint unsigned a[4];
		longint unsigned m;
		longint x, y, z, xn;
		int s;
		bit zu, zv;
		c[0] = o.center1_x; c[1] = o.center1_y; c[2] = o.center1_z;
		p[0] = o.point_x;   p[1] = o.point_y;   p[2] = o.point_z;
		u[0] = p[0] - c[0]; u[1] = p[1] - c[1]; u[2] = p[2] - c[2];
		v[0] = p[0] - longint'(o.center2_x);
		v[1] = p[1] - longint'(o.center2_y);
		v[2] = p[2] - longint'(o.center2_z);
		zu = (u[0] == 0) && (u[1] == 0) && (u[2] == 0);
		zv = (v[0] == 0) && (v[1] == 0) && (v[2] == 0);
		r.angle = '0;
		r.degenerate = 1'b0;
		if (zu || zv) begin
			r.degenerate = 1'b1;
			return r;
		end
		shrink_ray(u);
		shrink_ray(v);
		a[0] = magnitude(u[0] * v[0] + u[1] * v[1] + u[2] * v[2]);
		a[1] = magnitude(u[1] * v[2] - u[2] * v[1]);
		a[2] = magnitude(u[2] * v[0] - u[0] * v[2]);
		a[3] = magnitude(u[0] * v[1] - u[1] * v[0]);
		m = 0;
		for (int i = 0; i < 4; i++)
			if (a[i] > m)
				m = a[i];
		if (m == 0)
			return r;
		s = 0;
		if (m >= (64'd1 << 30)) begin
			while ((m >> s) >= (64'd1 << 30))
				s++;
			for (int i = 0; i < 4; i++)
				a[i] >>= s;
		end else begin
			while ((m << s) < (64'd1 << 29))
				s++;
			for (int i = 0; i < 4; i++)
				a[i] <<= s;
		end
		x = longint'(a[0]);
		y = longint'(int_sqrt(a[1] * a[1] + a[2] * a[2] + a[3] * a[3]));
		z = 0;
		// vector toward y = 0
		for (int i = 0; i < CordN; i++) begin
			if (y >= 0) begin
				xn = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += longint'(atan_q30(5'(i)));
			end else begin
				xn = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= longint'(atan_q30(5'(i)));
			end
			x = xn;
		end
		if (z <= 0)
			return r;
		z = (z + (64'd1 << 13)) >>> 14;
		if (z > AngMax)
			z = AngMax;
		r.angle = AngW'(z);
		return r;
	endfunction

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000)) - 1000);
			2: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
		endcase
	endfunction

	function automatic tri_in_t random_obs();
		tri_in_t o;
		int mode;
		int kind;
		mode = $urandom_range(0, 3);
		o.center1_x = rand_coord(mode); o.center1_y = rand_coord(mode);
		o.center1_z = rand_coord(mode); o.center2_x = rand_coord(mode);
		o.center2_y = rand_coord(mode); o.center2_z = rand_coord(mode);
		o.point_x = rand_coord(mode);   o.point_y = rand_coord(mode);
		o.point_z = rand_coord(mode);
		kind = $urandom_range(0, 19);
		// steer into coincident centres and zero rays now and then
		if (kind == 0) begin
			o.center2_x = o.center1_x; o.center2_y = o.center1_y;
			o.center2_z = o.center1_z;
		end else if (kind == 1) begin
			o.point_x = o.center1_x; o.point_y = o.center1_y; o.point_z = o.center1_z;
		end else if (kind == 2) begin
			o.point_x = o.center2_x; o.point_y = o.center2_y; o.point_z = o.center2_z;
		end
		return o;
	endfunction

	function automatic tri_in_t make_obs(int c1x, int c1y, int c1z, int c2x, int c2y,
			int c2z, int px, int py, int pz);
		tri_in_t o;
		o.center1_x = c1x; o.center1_y = c1y; o.center1_z = c1z;
		o.center2_x = c2x; o.center2_y = c2y; o.center2_z = c2z;
		o.point_x = px;    o.point_y = py;    o.point_z = pz;
		return o;
	endfunction

	// append one observation to the stimulus queue
	function automatic void add_obs(tri_in_t o);
		pending_obs = {pending_obs, o};
	endfunction

	// fill the stimulus queue
	initial begin
		int mn, mx, one;
		mn = 32'h8000_0000;
		mx = 32'h7fff_ffff;
		one = 32'h0001_0000;
		n_mismatch = 0;
		n_checked = 0;
		n_degenerate = 0;
		stim_done = 1'b0;
		quiet = 1'b0;
		add_obs(make_obs(0, 0, 0, 0, 0, 0, 0, 0, 0));
		add_obs(make_obs(0, 0, 0, one, 0, 0, 0, 0, 0));
		add_obs(make_obs(one, 0, 0, 0, 0, 0, 0, 0, 0));
		add_obs(make_obs(0, 0, 0, 0, 0, 0, one, one, 0));
		add_obs(make_obs(0, 0, 0, one, 0, 0, 0, one, 0));
		add_obs(make_obs(-one, 0, 0, one, 0, 0, 0, one, 0));
		add_obs(make_obs(-one, 0, 0, one, 0, 0, 0, 0, 0));
		add_obs(make_obs(-one, 0, 0, one, 0, 0, 0, 1, 0));
		add_obs(make_obs(mn, mn, mn, mx, mx, mx, mx, mn, mx));
		add_obs(make_obs(mx, mx, mx, mn, mn, mn, mn, mx, mn));
		add_obs(make_obs(mn, mn, mn, mn, mn, mn, mx, mx, mx));
		add_obs(make_obs(mx, 0, 0, mn, 0, 0, 0, mx, 0));
		add_obs(make_obs(mn, mx, mn, mx, mn, mx, 0, 0, 0));
		add_obs(make_obs(0, 0, 0, 1, 0, 0, 2, 0, 0));
		add_obs(make_obs(0, 0, 0, 0, 1, 0, 1, 0, 0));
		add_obs(make_obs(-1, -1, -1, 1, 1, 1, 0, 0, 0));
		add_obs(make_obs(mx, mx, mx, mx, mx, mx, mn, mn, mn));
		add_obs(make_obs(0, 0, 0, 2 * one, 0, 0, one, one, 0));
		for (int i = 0; i < NumRandom; i++)
			add_obs(random_obs());
	end

	// reset
	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// drive the input channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in <= '0;
			in_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				expected_angles = {expected_angles, predict_angle(in)};
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_obs.size() > 0) begin
				in_valid <= 1'b1;
				in <= pending_obs.pop_front();
				if (!quiet && $urandom_range(0, 9) == 0)
					in_gap <= $urandom_range(1, 11);
			end else begin
				in_valid <= 1'b0;
				stim_done <= 1'b1;
			end
		end
	end

	// stall the output channel and check each transfer
	always @(posedge clk or negedge arst_n) begin
		tri_out_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_angles.size() == 0) begin
					$error("unexpected result angle=%0d degenerate=%0d", out.angle,
						out.degenerate);
					n_mismatch++;
				end else begin
					e = expected_angles.pop_front();
					n_checked++;
					if (e.degenerate)
						n_degenerate++;
					if (out.angle !== e.angle) begin
						$error("angle: expected %0d, got %0d", e.angle, out.angle);
						n_mismatch++;
					end
					if (out.degenerate !== e.degenerate) begin
						$error("degenerate: expected %0d, got %0d", e.degenerate,
							out.degenerate);
						n_mismatch++;
					end
				end
			end
			if (out_gap > 0) begin
				out_stall <= 1'b1;
				out_gap <= out_gap - 1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				out_gap <= $urandom_range(0, 10);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// turn idling off near the end of the stimulus
	always @(posedge clk)
		if (pending_obs.size() < 200)
			quiet <= 1'b1;

	// wait for the last result, then report
	initial begin
		wait (stim_done);
		wait (expected_angles.size() == 0);
		repeat (Latency + 10) @(posedge clk);
		$display("Checked %0d observations, %0d with a zero-length ray.", n_checked,
			n_degenerate);
		if (n_mismatch == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// timeout
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== sim.f =====
design/tri_pkg.sv
design/tri_front.sv
design/tri_sqrt.sv
design/tri_cordic.sv
design/triangulation_angle.sv
test/tb_triangulation_angle.sv
